FILE: rtl/ascending_insertion_sorter_defines.svh
// assertion macros for the insertion sorter
`ifndef ASCENDING_INSERTION_SORTER_DEFINES_SVH
`define ASCENDING_INSERTION_SORTER_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define AIS_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("sorter assertion failed");

// next-cycle implication, sampled on i_clk, off during reset
`define AIS_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("sorter assertion failed");

`endif

FILE: rtl/ais_pkg.sv
package ais_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;

    typedef logic signed [DATA_W-1:0] t_value;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } t_state;

    // common controls broadcast to every cell
    typedef struct packed {
        logic   load_en;
        logic   drain_en;
        t_value sample;
    } t_cell_ctl;

    // what a cell shows its neighbors
    typedef struct packed {
        logic   valid;
        logic   greater;
        t_value value;
    } t_cell_link;

endpackage

FILE: rtl/ais_cell.sv
module ais_cell
    import ais_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctl  i_ctl,
    input  t_cell_link i_lower,
    input  t_cell_link i_upper,
    output t_cell_link o_link
);

    logic   r_valid;
    logic   n_valid;
    t_value r_value;
    t_value n_value;
    logic   greater;

    assign greater = r_valid && (r_value > i_ctl.sample);

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        if (i_ctl.drain_en) begin
            n_valid = i_upper.valid;
            n_value = i_upper.value;
        end else if (i_ctl.load_en && (greater || (!r_valid && i_lower.valid))) begin
            // shift up from below, or take the new word at the insertion point
            n_valid = 1'b1;
            n_value = i_lower.greater ? i_lower.value : i_ctl.sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_link.valid   = r_valid;
    assign o_link.greater = greater;
    assign o_link.value   = r_value;

endmodule

FILE: rtl/ascending_insertion_sorter.sv
// channel  | handshake          | payload
// ---------+--------------------+------------------------------------------------
// input    | i_valid / o_ready  | i_sample_value (s32), i_end_of_set
// output   | o_valid / i_ready  | o_sorted_value (s32), o_final_result,
//          |                    | o_dropped_flag
//
// loading: one word per cycle, inserted into the cell chain unless it is full
// draining: one word per cycle while i_ready is high
// o_ready is low from the word closing a set until the final result is taken
// synchronous active-low reset empties the chain, no clearing pass
// a stalled output holds the chain, nothing moves until the word is taken
`include "ascending_insertion_sorter_defines.svh"

module ascending_insertion_sorter
    import ais_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_value i_sample_value,
    input  logic   i_end_of_set,
    output logic   o_valid,
    input  logic   i_ready,
    output t_value o_sorted_value,
    output logic   o_final_result,
    output logic   o_dropped_flag
);

    t_state     r_state;
    t_state     n_state;
    logic       r_overflow;
    logic       n_overflow;
    t_cell_ctl  ctl;
    t_cell_link link [CAPACITY];
    logic       in_acc;
    logic       out_acc;
    logic       full;

    assign full    = link[CAPACITY-1].valid;
    assign o_ready = (r_state == ST_LOAD);
    assign in_acc  = i_valid && o_ready;
    assign o_valid = (r_state == ST_DRAIN) && link[0].valid;
    assign out_acc = o_valid && i_ready;

    assign ctl.load_en  = in_acc && !full;
    assign ctl.drain_en = out_acc;
    assign ctl.sample   = i_sample_value;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            t_cell_link lower;
            t_cell_link upper;
            if (gi == 0) begin : g_first
                assign lower = '{valid: 1'b1, greater: 1'b0, value: '0};
            end else begin : g_mid_lo
                assign lower = link[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign upper = '{valid: 1'b0, greater: 1'b0, value: '0};
            end else begin : g_mid_hi
                assign upper = link[gi+1];
            end
            ais_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (ctl),
                .i_lower (lower),
                .i_upper (upper),
                .o_link  (link[gi])
            );
        end
    endgenerate

    assign o_sorted_value = link[0].value;
    assign o_final_result = !link[1].valid;
    assign o_dropped_flag = r_overflow;

    always_comb begin
        n_state    = r_state;
        n_overflow = r_overflow;
        case (r_state)
            ST_LOAD: begin
                if (in_acc && full) begin
                    n_overflow = 1'b1;
                end
                if (in_acc && i_end_of_set) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (out_acc && o_final_result) begin
                    n_state    = ST_LOAD;
                    n_overflow = 1'b0;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_overflow <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_overflow <= n_overflow;
        end
    end

    `AIS_ASSERT_IMP(a_no_overlap, o_ready, !o_valid)
    `AIS_ASSERT_NXT(a_close_drains, in_acc && i_end_of_set, o_valid)
    `AIS_ASSERT_NXT(a_full_drops, in_acc && full, r_overflow)
    `AIS_ASSERT_NXT(a_final_empties, out_acc && o_final_result, o_ready && !link[0].valid)

endmodule
